// ===== hw/rtl/atapio_pkg.sv =====
// shared constants, types and identify template for the ata pio task file device
`timescale 1ns / 1ps
`default_nettype none
package atapio_pkg;

   localparam int IMAGE_SECTORS = 64;
   localparam int SECTOR_BYTES  = 512;
   localparam int STORE_BYTES   = IMAGE_SECTORS * SECTOR_BYTES;
   localparam int POS_W         = $clog2(SECTOR_BYTES);
   localparam int LBA_IDX_W     = $clog2(IMAGE_SECTORS);
   localparam int STORE_AW      = $clog2(STORE_BYTES);
   localparam int NS_W          = 7;
   localparam int LBA_W         = 28;

   // request operations
   localparam logic [1:0] OP_READ    = 2'd0;
   localparam logic [1:0] OP_WRITE   = 2'd1;
   localparam logic [1:0] OP_PRELOAD = 2'd2;

   // host map
   localparam logic [15:0] WIN_LO   = 16'h7C00;
   localparam logic [15:0] WIN_HI   = 16'h7DFF;
   localparam logic [15:0] REG_BASE = 16'h7E00;
   localparam logic [15:0] REG_LAST = 16'h7E07;
   localparam logic [15:0] CTL_ADDR = 16'h7E0E;

   // task file register offsets
   localparam logic [2:0] REG_DATA  = 3'd0;
   localparam logic [2:0] REG_ERR   = 3'd1;
   localparam logic [2:0] REG_COUNT = 3'd2;
   localparam logic [2:0] REG_LBAL  = 3'd3;
   localparam logic [2:0] REG_LBAM  = 3'd4;
   localparam logic [2:0] REG_LBAH  = 3'd5;
   localparam logic [2:0] REG_DEVH  = 3'd6;
   localparam logic [2:0] REG_CMD   = 3'd7;

   // commands
   localparam logic [7:0] CMD_DIAG  = 8'h90;
   localparam logic [7:0] CMD_IDENT = 8'hEC;
   localparam logic [7:0] CMD_READ  = 8'h20;
   localparam logic [7:0] CMD_WRITE = 8'h30;

   // status and error codes
   localparam logic [7:0] ST_READY     = 8'h50;
   localparam logic [7:0] ST_DRQ_READ  = 8'h58;
   localparam logic [7:0] ST_DRQ_WRITE = 8'h48;
   localparam logic [7:0] ST_ERROR     = 8'h51;
   localparam logic [7:0] ERR_DIAG     = 8'h01;
   localparam logic [7:0] ERR_NONE     = 8'h00;
   localparam logic [7:0] ERR_ABRT     = 8'h04;
   localparam logic [7:0] ERR_IDNF     = 8'h10;
   localparam int         ST_DRQ_BIT   = 3;
   localparam int         CTL_SRST_BIT = 2;

   // configuration register indexes
   localparam logic CSR_SECTOR_TOTAL = 1'b0;
   localparam logic CSR_ATTACHED     = 1'b1;

   // data buffer source
   localparam logic [1:0] SRC_ZERO  = 2'd0;
   localparam logic [1:0] SRC_IDENT = 2'd1;
   localparam logic [1:0] SRC_DISK  = 2'd2;

   typedef struct packed {
      logic                claimed;
      logic                use_mem;
      logic [7:0]          rd_byte;
      logic [STORE_AW-1:0] mem_addr;
   } tf_rsp_type;

   localparam logic [8*20-1:0] SERIAL_TXT = {"REFDISK00000001", {5{8'h20}}};
   localparam logic [8*8-1:0]  FW_TXT     = {"1.0", {5{8'h20}}};
   localparam logic [8*40-1:0] MODEL_TXT  = {"Virtual ATA Disk", {24{8'h20}}};

   // identify template byte; with at most 64 sectors the cylinder count clamps to 1
   function automatic logic [7:0] identify_byte(logic [POS_W-1:0] p, logic [NS_W-1:0] ns);
      logic [POS_W-1:0] k;
      logic [7:0]       b;
      begin
         b = 8'h00;
         k = '0;
         if (p == 9'd0) b = 8'h40;
         else if (p == 9'd2) b = 8'h01;
         else if (p == 9'd6) b = 8'd16;
         else if (p == 9'd12) b = 8'd63;
         else if (p >= 9'd20 && p < 9'd40) begin
            k = (p - 9'd20) ^ 9'd1;
            b = SERIAL_TXT[8*(19 - k[4:0]) +: 8];
         end else if (p >= 9'd46 && p < 9'd54) begin
            k = (p - 9'd46) ^ 9'd1;
            b = FW_TXT[8*(7 - k[2:0]) +: 8];
         end else if (p >= 9'd54 && p < 9'd94) begin
            k = (p - 9'd54) ^ 9'd1;
            b = MODEL_TXT[8*(39 - k[5:0]) +: 8];
         end else if (p == 9'd94) b = 8'h01;
         else if (p == 9'd95) b = 8'h80;
         else if (p == 9'd99) b = 8'h02;
         else if (p == 9'd106) b = 8'h01;
         else if (p == 9'd120) b = {1'b0, ns};
         return b;
      end
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ata_pio_task_file_device.sv =====
// top level of the ata pio task file device with registered response path
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | req_op, req_bus_address, req_write_byte,
//          |           |                    | req_image_index
//  rsp     | out       | rsp_valid/rsp_stall | rsp_claimed, rsp_read_byte
//  csr     | in        | csr_write          | csr_index, csr_data
//
// one request a cycle while req_stall is low; each response passes the first stage, then the output register
// the first stage holds the disk store read port and the request registers
// reset is synchronous and clears the task file and pipeline, the disk store is kept
// a stalled response holds the output register; requests stall while both stages are full and rsp_stall is high
`timescale 1ns / 1ps
`default_nettype none
module ata_pio_task_file_device (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [1:0]                  req_op,
   input  wire logic [15:0]                 req_bus_address,
   input  wire logic [7:0]                  req_write_byte,
   input  wire logic [14:0]                 req_image_index,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_claimed,
   output logic [7:0]                       rsp_read_byte,
   input  wire logic                        csr_write,
   input  wire logic                        csr_index,
   input  wire logic [atapio_pkg::NS_W-1:0] csr_data
);
   logic                   accept;
   atapio_pkg::tf_rsp_type tf_rsp;
   logic [7:0]             mem_q;
   logic                   s1_valid_ff, s1_valid_in, s1_claimed_ff, s1_use_mem_ff;
   logic [7:0]             s1_byte_ff;
   logic                   s1_move;
   logic                   out_valid_ff, out_valid_in, out_claimed_ff;
   logic [7:0]             out_byte_ff;

   // request taken when the first stage is free or moving on
   assign req_stall = s1_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);

   atapio_task_file u_task_file (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .op          (req_op),
      .bus_address (req_bus_address),
      .write_byte  (req_write_byte),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp         (tf_rsp)
   );

   // preload writes and data reads share the store; read data held until the next request
   atapio_disk_mem u_disk_mem (
      .clock   (clock),
      .wr_en   (accept && req_op == atapio_pkg::OP_PRELOAD),
      .wr_addr (req_image_index),
      .wr_data (req_write_byte),
      .rd_en   (accept),
      .rd_addr (tf_rsp.mem_addr),
      .rd_data (mem_q)
   );

   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign out_valid_in = s1_move || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_claimed_ff <= tf_rsp.claimed;
         s1_use_mem_ff <= tf_rsp.use_mem;
         s1_byte_ff    <= tf_rsp.rd_byte;
      end
      if (s1_move) begin
         out_claimed_ff <= s1_claimed_ff;
         out_byte_ff    <= s1_use_mem_ff ? mem_q : s1_byte_ff;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_claimed   = out_claimed_ff;
   assign rsp_read_byte = out_byte_ff;

   a_unclaimed_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_claimed_ff |-> out_byte_ff == 8'h00)
      else $error("unclaimed response carries data");
   a_s1_kept: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |=> s1_valid_ff)
      else $error("waiting response lost");
   a_mem_claimed: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_use_mem_ff |-> s1_claimed_ff)
      else $error("memory byte on unclaimed response");
endmodule
`default_nettype wire

// ===== hw/rtl/atapio_disk_mem.sv =====
// disk image store, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module atapio_disk_mem (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [atapio_pkg::STORE_AW-1:0] wr_addr,
   input  wire logic [7:0]                    wr_data,
   input  wire logic                          rd_en,
   input  wire logic [atapio_pkg::STORE_AW-1:0] rd_addr,
   output logic      [7:0]                    rd_data
);
   logic [7:0] store_ff [atapio_pkg::STORE_BYTES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= store_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/atapio_task_file.sv =====
// task file, command execution and data transfer bookkeeping
`timescale 1ns / 1ps
`default_nettype none
module atapio_task_file (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           accept,
   input  wire logic [1:0]                     op,
   input  wire logic [15:0]                    bus_address,
   input  wire logic [7:0]                     write_byte,
   input  wire logic                           csr_write,
   input  wire logic                           csr_index,
   input  wire logic [atapio_pkg::NS_W-1:0]    csr_data,
   output atapio_pkg::tf_rsp_type              rsp
);
   logic [atapio_pkg::NS_W-1:0]  total_ff;
   logic                         attached_ff;
   logic [7:0] error_ff, error_in, count_ff, count_in, lbal_ff, lbal_in;
   logic [7:0] lbam_ff, lbam_in, lbah_ff, lbah_in, devh_ff, devh_in, status_ff, status_in;
   logic       srst_ff, srst_in;
   logic [atapio_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0] left_ff, left_in;
   logic [atapio_pkg::LBA_W-1:0] next_ff, next_in, cur_ff, cur_in;
   logic [1:0] src_ff, src_in;
   logic       wact_ff, wact_in;
   logic [atapio_pkg::NS_W-1:0]  ns;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         attached_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            atapio_pkg::CSR_SECTOR_TOTAL: total_ff <= csr_data;
            atapio_pkg::CSR_ATTACHED:     attached_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign ns = (total_ff < atapio_pkg::NS_W'(atapio_pkg::IMAGE_SECTORS)) ?
               total_ff : atapio_pkg::NS_W'(atapio_pkg::IMAGE_SECTORS);

   always_comb begin
      logic       in_window, in_regs, is_data, drq_done;
      logic [2:0] r;
      logic [atapio_pkg::LBA_W-1:0] lba;
      in_window = bus_address >= atapio_pkg::WIN_LO && bus_address <= atapio_pkg::WIN_HI;
      in_regs   = bus_address >= atapio_pkg::REG_BASE && bus_address <= atapio_pkg::REG_LAST;
      r         = bus_address[2:0];
      is_data   = in_window || (in_regs && r == atapio_pkg::REG_DATA);
      drq_done  = (pos_ff == '1);
      lba       = {devh_ff[3:0], lbah_ff, lbam_ff, lbal_ff};
      error_in = error_ff; count_in = count_ff; lbal_in = lbal_ff; lbam_in = lbam_ff;
      lbah_in = lbah_ff; devh_in = devh_ff; status_in = status_ff; srst_in = srst_ff;
      pos_in = pos_ff; left_in = left_ff; next_in = next_ff; cur_in = cur_ff;
      src_in = src_ff; wact_in = wact_ff;
      rsp = '{claimed: 1'b0, use_mem: 1'b0, rd_byte: 8'h00,
              mem_addr: {cur_ff[atapio_pkg::LBA_IDX_W-1:0], pos_ff}};

      unique case (op)
         atapio_pkg::OP_READ: begin
            if (is_data) begin
               rsp.claimed = 1'b1;
               if (!status_ff[atapio_pkg::ST_DRQ_BIT] || wact_ff) begin
                  rsp.rd_byte = 8'hFF;
               end else begin
                  if (src_ff == atapio_pkg::SRC_IDENT) begin
                     rsp.rd_byte = atapio_pkg::identify_byte(pos_ff, ns);
                  end
                  rsp.use_mem = (src_ff == atapio_pkg::SRC_DISK);
                  pos_in = pos_ff + 1'b1;
                  if (drq_done) begin
                     if (left_ff == 8'd0) begin
                        status_in = atapio_pkg::ST_READY;
                     end else begin
                        cur_in  = next_ff;
                        src_in  = (attached_ff && next_ff < atapio_pkg::LBA_W'(ns)) ?
                                  atapio_pkg::SRC_DISK : atapio_pkg::SRC_ZERO;
                        next_in = next_ff + 1'b1;
                        left_in = left_ff - 1'b1;
                        status_in = atapio_pkg::ST_DRQ_READ;
                     end
                  end
               end
            end else if (in_regs) begin
               rsp.claimed = 1'b1;
               unique case (r)
                  atapio_pkg::REG_ERR:   rsp.rd_byte = error_ff;
                  atapio_pkg::REG_COUNT: rsp.rd_byte = count_ff;
                  atapio_pkg::REG_LBAL:  rsp.rd_byte = lbal_ff;
                  atapio_pkg::REG_LBAM:  rsp.rd_byte = lbam_ff;
                  atapio_pkg::REG_LBAH:  rsp.rd_byte = lbah_ff;
                  atapio_pkg::REG_DEVH:  rsp.rd_byte = devh_ff;
                  default:               rsp.rd_byte = status_ff;
               endcase
            end else if (bus_address == atapio_pkg::CTL_ADDR) begin
               rsp.claimed = 1'b1;
               rsp.rd_byte = status_ff;
            end
         end
         atapio_pkg::OP_WRITE: begin
            if (is_data) begin
               if (wact_ff) begin
                  pos_in = pos_ff + 1'b1;
                  if (drq_done) begin
                     if (left_ff == 8'd0) begin
                        wact_in   = 1'b0;
                        status_in = atapio_pkg::ST_READY;
                     end else begin
                        left_in   = left_ff - 1'b1;
                        status_in = atapio_pkg::ST_DRQ_WRITE;
                     end
                  end
               end
            end else if (in_regs) begin
               unique case (r)
                  atapio_pkg::REG_COUNT: count_in = write_byte;
                  atapio_pkg::REG_LBAL:  lbal_in = write_byte;
                  atapio_pkg::REG_LBAM:  lbam_in = write_byte;
                  atapio_pkg::REG_LBAH:  lbah_in = write_byte;
                  atapio_pkg::REG_DEVH:  devh_in = write_byte;
                  atapio_pkg::REG_CMD: begin
                     wact_in = 1'b0;
                     unique case (write_byte)
                        atapio_pkg::CMD_DIAG: begin
                           error_in  = atapio_pkg::ERR_DIAG;
                           status_in = atapio_pkg::ST_READY;
                        end
                        atapio_pkg::CMD_IDENT: begin
                           src_in = atapio_pkg::SRC_IDENT;
                           pos_in = '0;
                           left_in = 8'd0;
                           error_in = atapio_pkg::ERR_NONE;
                           status_in = atapio_pkg::ST_DRQ_READ;
                        end
                        atapio_pkg::CMD_READ: begin
                           if (!attached_ff || lba >= atapio_pkg::LBA_W'(ns)) begin
                              error_in  = atapio_pkg::ERR_IDNF;
                              status_in = atapio_pkg::ST_ERROR;
                           end else begin
                              cur_in  = lba;
                              src_in  = atapio_pkg::SRC_DISK;
                              next_in = lba + 1'b1;
                              pos_in  = '0;
                              left_in = count_ff - 1'b1;
                              error_in  = atapio_pkg::ERR_NONE;
                              status_in = atapio_pkg::ST_DRQ_READ;
                           end
                        end
                        atapio_pkg::CMD_WRITE: begin
                           wact_in = 1'b1;
                           pos_in  = '0;
                           left_in = count_ff - 1'b1;
                           error_in  = atapio_pkg::ERR_NONE;
                           status_in = atapio_pkg::ST_DRQ_WRITE;
                        end
                        default: begin
                           error_in  = atapio_pkg::ERR_ABRT;
                           status_in = atapio_pkg::ST_ERROR;
                        end
                     endcase
                  end
                  default: ;
               endcase
            end else if (bus_address == atapio_pkg::CTL_ADDR) begin
               srst_in = write_byte[atapio_pkg::CTL_SRST_BIT];
               // software reset on a falling srst bit
               if (srst_ff && !write_byte[atapio_pkg::CTL_SRST_BIT]) begin
                  error_in = atapio_pkg::ERR_DIAG; count_in = 8'h01; lbal_in = 8'h01;
                  lbam_in = 8'h00; lbah_in = 8'h00; devh_in = 8'h00;
                  status_in = atapio_pkg::ST_READY; srst_in = 1'b0;
                  pos_in = '0; left_in = 8'd0; next_in = '0; cur_in = '0;
                  src_in = atapio_pkg::SRC_ZERO; wact_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_ff <= atapio_pkg::ERR_DIAG; count_ff <= 8'h01; lbal_ff <= 8'h01;
         lbam_ff <= 8'h00; lbah_ff <= 8'h00; devh_ff <= 8'h00;
         status_ff <= atapio_pkg::ST_READY; srst_ff <= 1'b0;
         pos_ff <= '0; left_ff <= 8'd0; next_ff <= '0; cur_ff <= '0;
         src_ff <= atapio_pkg::SRC_ZERO; wact_ff <= 1'b0;
      end else if (accept) begin
         error_ff <= error_in; count_ff <= count_in; lbal_ff <= lbal_in;
         lbam_ff <= lbam_in; lbah_ff <= lbah_in; devh_ff <= devh_in;
         status_ff <= status_in; srst_ff <= srst_in;
         pos_ff <= pos_in; left_ff <= left_in; next_ff <= next_in; cur_ff <= cur_in;
         src_ff <= src_in; wact_ff <= wact_in;
      end
   end

   a_disk_src_in_range: assert property (@(posedge clock) disable iff (reset)
      src_ff == atapio_pkg::SRC_DISK |-> cur_ff < atapio_pkg::LBA_W'(atapio_pkg::IMAGE_SECTORS))
      else $error("disk source beyond the store");
   a_write_has_drq: assert property (@(posedge clock) disable iff (reset)
      wact_ff |-> status_ff == atapio_pkg::ST_DRQ_WRITE)
      else $error("write transfer without drq status");
   a_mem_only_claimed: assert property (@(posedge clock) disable iff (reset)
      rsp.use_mem |-> rsp.claimed && rsp.rd_byte == 8'h00)
      else $error("memory byte on an unclaimed read");
endmodule
`default_nettype wire
